FILE: sv/rmi_pkg.sv
// ----------------------------------------------------------------------------
// rmi_pkg: shared types and constants of the running median block
// Field widths of the stream words and the control groups that pass
// between the top level and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rmi_pkg;

  localparam int SampleW = 32;  // sample and median width
  localparam int HeldW   = 11;  // held_count field width
  localparam int OutW    = 48;  // median + held_count, padded to bytes

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic                      ins;  // insert this cycle
    logic signed [SampleW-1:0] x;    // sample being inserted
  } rmi_bcast_t;

  // Result sideband that travels beside the selection tree.
  typedef struct packed {
    logic             res;      // stage carries a result word
    logic             dropped;  // sample was dropped, store full
    logic [HeldW-1:0] held;     // samples held after the step
  } rmi_side_t;

endpackage : rmi_pkg

`default_nettype wire

FILE: sv/running_median_insertion.sv
// ----------------------------------------------------------------------------
// running_median_insertion: running median by sorted insertion
// Keeps the current data set sorted in a row of cells and reports the median
// after every sample that leaves an odd held count, and flags a dropped sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_axis channel: tdata carries the signed sample,
//   tuser raises start_set, which empties the store before the sample goes in.
//   Result words leave on the m_axis channel: tdata carries median and
//   held_count, tuser flags a sample dropped because the store was full.
//   A word gives a result after an odd held count or on a drop; a word that
//   leaves an even count gives none.
// Timing:
//   The sample is inserted into the cell row at the accept edge, all cells
//   comparing in parallel. The median is then gathered by a registered 4-way
//   OR tree of ceil(log4(CAPACITY)) levels (5 for 1024 entries), whose root
//   feeds the median field of the result word.
//   One word per cycle is taken while the result side keeps up.
// Reset and stall:
//   Reset empties the store (count to zero) and clears all pending results.
//   While a result word waits on m_axis_tready the whole pipe holds and
//   s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_insertion
  import rmi_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  // input stream
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // [31:0] sample
  input  wire logic         s_axis_tuser,   // [0] start_set
  // result stream
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [OutW-1:0]   m_axis_tdata,   // [31:0] median, [42:32] held_count
  output logic              m_axis_tuser    // [0] dropped
);

  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int IdxW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int Levels = (CAPACITY > 1) ? ($clog2(CAPACITY) + 1) / 2 : 1;
  localparam int Leaves = 1 << (2 * Levels);

  // Pipe control: every stage advances together unless the output word stalls.
  logic       adv;
  logic       accept;
  rmi_bcast_t bc;

  logic [CntW-1:0] count_q, count_d, count_eff, count_inc;
  logic            full;

  logic            sel_en_q, sel_en_d;   // stage 0: median pick is live
  logic [IdxW-1:0] mid_q, mid_d;         // stage 0: median index

  rmi_side_t side_q [Levels + 1];
  rmi_side_t side_d;

  logic signed [SampleW-1:0] cell_val [CAPACITY];
  logic                      cell_gt  [CAPACITY];
  logic        [SampleW-1:0] leaf     [Leaves];
  logic        [SampleW-1:0] root;

  assign adv           = !side_q[Levels].res || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // Start of a new set empties the store before this sample goes in.
  assign count_eff = s_axis_tuser ? '0 : count_q;
  assign full      = count_eff == CntW'(CAPACITY);
  assign count_inc = count_eff + CntW'(1);

  assign bc.ins = accept && !full;
  assign bc.x   = $signed(s_axis_tdata);

  // Next count, stage-0 sideband and median index.
  always_comb begin
    count_d  = count_q;
    sel_en_d = 1'b0;
    mid_d    = mid_q;
    side_d   = '0;
    if (accept) begin
      if (full) begin
        side_d.res     = 1'b1;
        side_d.dropped = 1'b1;
        side_d.held    = HeldW'(CAPACITY);
      end else begin
        count_d     = count_inc;
        side_d.res  = count_inc[0];
        side_d.held = HeldW'(count_inc);
        sel_en_d    = count_inc[0];
        mid_d       = IdxW'(count_inc >> 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sel_en_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (adv) begin
        sel_en_q <= sel_en_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mid_q <= mid_d;
    end
  end

  // Sideband pipe, aligned with the tree levels; the last stage is the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Levels; s++) begin
        side_q[s] <= '0;
      end
    end else if (adv) begin
      side_q[0] <= side_d;
      for (int s = 1; s <= Levels; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Sorted cell row: each cell hands its value to the right on an insert.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      rmi_cell #(.Index(i), .CntW(CntW)) u_cell (
        .clk_i      (clk_i),
        .bc_i       (bc),
        .count_i    (count_eff),
        .left_val_i ('0),
        .left_gt_i  (1'b0),
        .val_o      (cell_val[i]),
        .gt_o       (cell_gt[i])
      );
    end else begin : g_body
      rmi_cell #(.Index(i), .CntW(CntW)) u_cell (
        .clk_i      (clk_i),
        .bc_i       (bc),
        .count_i    (count_eff),
        .left_val_i (cell_val[i-1]),
        .left_gt_i  (cell_gt[i-1]),
        .val_o      (cell_val[i]),
        .gt_o       (cell_gt[i])
      );
    end
  end

  // Mask every cell but the median one; pad unused leaves with zero.
  for (genvar j = 0; j < Leaves; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_used
      assign leaf[j] = (sel_en_q && (mid_q == IdxW'(j))) ? cell_val[j] : '0;
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  rmi_sel_tree #(.Width(SampleW), .Levels(Levels)) u_tree (
    .clk_i  (clk_i),
    .en_i   (adv),
    .leaf_i (leaf),
    .root_o (root)
  );

  assign m_axis_tvalid = side_q[Levels].res;
  assign m_axis_tdata  = {{(OutW - SampleW - HeldW){1'b0}}, side_q[Levels].held, root};
  assign m_axis_tuser  = side_q[Levels].dropped;

endmodule : running_median_insertion

`default_nettype wire

FILE: sv/rmi_cell.sv
// ----------------------------------------------------------------------------
// rmi_cell: one slot of the sorted insertion chain
// Holds one sample; on an insert it keeps its value, takes the new sample
// or takes its left neighbor's value, which keeps the row sorted.
// ----------------------------------------------------------------------------
`default_nettype none

module rmi_cell
  import rmi_pkg::*;
#(
  parameter int Index = 0,
  parameter int CntW  = 11
) (
  input  wire                             clk_i,
  input  wire rmi_bcast_t                 bc_i,
  input  wire logic        [CntW-1:0]     count_i,     // held count before insert
  input  wire logic signed [SampleW-1:0]  left_val_i,
  input  wire logic                       left_gt_i,
  output logic signed      [SampleW-1:0]  val_o,
  output logic                            gt_o         // occupied and above x
);

  logic signed [SampleW-1:0] val_q, val_d;
  logic                      occupied;
  logic                      at_end;

  assign occupied = CntW'(Index) < count_i;
  assign at_end   = CntW'(Index) == count_i;
  assign gt_o     = occupied && (val_q > bc_i.x);

  // Shift right behind the insertion point, drop the sample into the gap.
  always_comb begin
    if (left_gt_i) begin
      val_d = left_val_i;
    end else if (gt_o || at_end) begin
      val_d = bc_i.x;
    end else begin
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bc_i.ins) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule : rmi_cell

`default_nettype wire

FILE: sv/rmi_sel_tree.sv
// ----------------------------------------------------------------------------
// rmi_sel_tree: registered four-way OR tree
// Combines one-hot masked leaves into a single word, one register per level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmi_sel_tree
  import rmi_pkg::*;
#(
  parameter int Width  = 32,
  parameter int Levels = 5
) (
  input  wire              clk_i,
  input  wire              en_i,
  input  wire logic [Width-1:0] leaf_i [1 << (2 * Levels)],
  output logic [Width-1:0] root_o
);

  localparam int Leaves = 1 << (2 * Levels);
  localparam int Nodes  = (Leaves - 1) / 3;

  logic [Width-1:0] node_q [Nodes];
  logic [Width-1:0] tree_w [Nodes + Leaves];

  for (genvar k = 0; k < Nodes; k++) begin : g_node
    assign tree_w[k] = node_q[k];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        node_q[k] <= tree_w[4*k+1] | tree_w[4*k+2] | tree_w[4*k+3] | tree_w[4*k+4];
      end
    end
  end

  for (genvar j = 0; j < Leaves; j++) begin : g_leaf
    assign tree_w[Nodes + j] = leaf_i[j];
  end

  assign root_o = node_q[0];

endmodule : rmi_sel_tree

`default_nettype wire

FILE: sv/rmi_checker.sv
// ----------------------------------------------------------------------------
// rmi_checker: port-level checks of the running median block
// Watches the result stream and the input handshake; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmi_checker
  import rmi_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              s_axis_tready,
  input wire              m_axis_tvalid,
  input wire              m_axis_tready,
  input wire [OutW-1:0]   m_axis_tdata,
  input wire              m_axis_tuser
);

  // Hold a stalled result word.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed under stall");

  // A drop reports a full store and a zero median.
  a_drop_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[SampleW-1:0] == '0
      && m_axis_tdata[SampleW+HeldW-1:SampleW] == HeldW'(CAPACITY))
    else $error("drop word malformed");

  // A median is only reported for an odd, in-range held count.
  a_odd_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[SampleW] && m_axis_tdata[SampleW+HeldW-1:SampleW] <= HeldW'(CAPACITY))
    else $error("median with bad held count");

  // Input side only stalls behind a waiting result.
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled without backpressure");

  // Padding bits of the result word stay zero.
  a_pad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutW-1:SampleW+HeldW] == '0)
    else $error("result padding not zero");

endmodule : rmi_checker

bind running_median_insertion rmi_checker #(.CAPACITY(CAPACITY)) u_rmi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
